/* rtl/core/kps_pkg.sv */
// Keypad scanner package: scan phase codes, event codes, register indexes,
// the configuration bundle and the key character table.
// No dependencies.
package kps_pkg;

  localparam int unsigned ColW    = 4;
  localparam int unsigned RowW    = 4;
  localparam int unsigned WaitW   = 16;
  localparam int unsigned MinHoldW = 24;
  localparam int unsigned CharW   = 8;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 24;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] CfgSettle  = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgConfirm = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgRow     = 2'd2;
  localparam logic [CfgAddrW-1:0] CfgMinHold = 2'd3;

  localparam logic [WaitW-1:0]    SettleRst  = 16'd2;
  localparam logic [WaitW-1:0]    ConfirmRst = 16'd1000;
  localparam logic [WaitW-1:0]    RowRst     = 16'd1000;
  localparam logic [MinHoldW-1:0] MinHoldRst = 24'd100000;

  typedef enum logic [3:0] {
    PhSettle  = 4'b0001,
    PhConfirm = 4'b0010,
    PhRow     = 4'b0100,
    PhHold    = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvKey   = 2'd1,
    EvShort = 2'd2,
    EvEmpty = 2'd3
  } event_e;

  typedef struct packed {
    logic [WaitW-1:0]    settle_ticks;
    logic [WaitW-1:0]    confirm_ticks;
    logic [WaitW-1:0]    row_ticks;
    logic [MinHoldW-1:0] min_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [RowW-1:0]  row_drive;
    event_e           key_event;
    logic [CharW-1:0] key_char;
  } result_t;

  // Key characters indexed by row and column
  function automatic logic [CharW-1:0] key_char_lookup(input logic [1:0] row,
                                                       input logic [1:0] col);
    logic [CharW-1:0] ch;
    case ({row, col})
      4'h0: ch = "D";
      4'h1: ch = "#";
      4'h2: ch = "0";
      4'h3: ch = "*";
      4'h4: ch = "C";
      4'h5: ch = "9";
      4'h6: ch = "8";
      4'h7: ch = "7";
      4'h8: ch = "B";
      4'h9: ch = "6";
      4'hA: ch = "5";
      4'hB: ch = "4";
      4'hC: ch = "A";
      4'hD: ch = "1";
      4'hE: ch = "2";
      4'hF: ch = "3";
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/core/matrix_keypad_scanner.sv */
// Top level of the 4x4 keypad scanner: stream ports, configuration registers,
// input and result registers around kps_core. Depends on kps_pkg, kps_core.
//
// One input transaction is one timer tick carrying the sampled active-low
// column levels; each tick yields exactly one result transaction with the row
// drive levels for that tick, an event code and, for an accepted key, its
// character. The block takes one tick per clock while nothing stalls: a tick
// is registered, passed through the combinational scan sequencer logic and
// lands in the result register, so throughput is one transaction per cycle.
// Input stalls only while the result register is full and not taken.
// Configuration writes take effect at once and are meant for idle periods.
// Hold timing counts HOLD_BITS bits and saturates.
module matrix_keypad_scanner #(
  parameter int unsigned HOLD_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input ticks
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // [3:0] column_levels
  // results
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [15:0]                   m_axis_tdata_o,  // [3:0] row_drive, [11:4] key_char
  output logic [1:0]                    m_axis_tuser_o,  // [1:0] key_event
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [kps_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [kps_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  kps_pkg::cfg_t                cfg_q;
  logic                         in_valid_q;
  logic [kps_pkg::ColW-1:0]     cols_q;
  logic                         out_valid_q;
  kps_pkg::result_t             res_q;
  kps_pkg::result_t             res_d;
  logic                         advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ticks   <= kps_pkg::SettleRst;
      cfg_q.confirm_ticks  <= kps_pkg::ConfirmRst;
      cfg_q.row_ticks      <= kps_pkg::RowRst;
      cfg_q.min_hold_ticks <= kps_pkg::MinHoldRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        kps_pkg::CfgSettle:  cfg_q.settle_ticks  <= cfg_wdata_i[kps_pkg::WaitW-1:0];
        kps_pkg::CfgConfirm: cfg_q.confirm_ticks <= cfg_wdata_i[kps_pkg::WaitW-1:0];
        kps_pkg::CfgRow:     cfg_q.row_ticks     <= cfg_wdata_i[kps_pkg::WaitW-1:0];
        kps_pkg::CfgMinHold: cfg_q.min_hold_ticks <= cfg_wdata_i[kps_pkg::MinHoldW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cols_q <= s_axis_tdata_i[kps_pkg::ColW-1:0];
    end
  end

  kps_core #(
    .HOLD_BITS (HOLD_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cols_i (cols_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, res_q.key_char, res_q.row_drive};
  assign m_axis_tuser_o  = res_q.key_event;

endmodule

/* rtl/core/kps_core.sv */
// Keypad scanner sequencer: scan state registers and the per-tick next-state
// and result logic. Depends on kps_pkg.
module kps_core #(
  parameter int unsigned HOLD_BITS = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [kps_pkg::ColW-1:0]  cols_i,
  input  kps_pkg::cfg_t             cfg_i,
  output kps_pkg::result_t          res_o
);

  localparam int unsigned CmpW = (HOLD_BITS > kps_pkg::MinHoldW) ? HOLD_BITS
                                                                   : kps_pkg::MinHoldW;

  kps_pkg::phase_e               phase_q, phase_d;
  logic [kps_pkg::WaitW-1:0]     wait_q, wait_d;
  logic [1:0]                    row_q, row_d;
  logic [1:0]                    col_q, col_d;
  logic [HOLD_BITS-1:0]          hold_q, hold_d;

  logic                          any_low;
  logic [1:0]                    low_col;
  logic [kps_pkg::RowW-1:0]      sel_drive;
  logic [kps_pkg::WaitW-1:0]     wait_inc;
  logic [CmpW-1:0]               hold_ext;
  logic [CmpW-1:0]               min_ext;

  assign any_low   = (cols_i != '1);
  assign sel_drive = ~(kps_pkg::RowW'(1) << row_q);
  assign wait_inc  = wait_q + kps_pkg::WaitW'(1);
  assign hold_ext  = CmpW'(hold_q);
  assign min_ext   = CmpW'(cfg_i.min_hold_ticks);

  // Lowest pressed column
  always_comb begin
    if (!cols_i[0]) begin
      low_col = 2'd0;
    end else if (!cols_i[1]) begin
      low_col = 2'd1;
    end else if (!cols_i[2]) begin
      low_col = 2'd2;
    end else begin
      low_col = 2'd3;
    end
  end

  always_comb begin
    phase_d = phase_q;
    wait_d  = wait_q;
    row_d   = row_q;
    col_d   = col_q;
    hold_d  = hold_q;
    res_o.row_drive = '0;
    res_o.key_event = kps_pkg::EvNone;
    res_o.key_char  = '0;

    case (phase_q)
      kps_pkg::PhConfirm: begin
        if (wait_q < cfg_i.confirm_ticks) begin
          wait_d = wait_inc;
        end else if (any_low) begin
          phase_d = kps_pkg::PhRow;
          row_d   = '0;
          wait_d  = '0;
        end else begin
          res_o.key_event = kps_pkg::EvEmpty;
          phase_d = kps_pkg::PhSettle;
          wait_d  = '0;
        end
      end
      kps_pkg::PhRow: begin
        res_o.row_drive = sel_drive;
        if (wait_q < cfg_i.row_ticks) begin
          wait_d = wait_inc;
        end else if (any_low) begin
          col_d   = low_col;
          hold_d  = '0;
          phase_d = kps_pkg::PhHold;
        end else if (row_q == 2'd3) begin
          res_o.key_event = kps_pkg::EvEmpty;
          phase_d = kps_pkg::PhSettle;
          wait_d  = '0;
        end else begin
          row_d  = row_q + 2'd1;
          wait_d = '0;
        end
      end
      kps_pkg::PhHold: begin
        res_o.row_drive = sel_drive;
        if (!cols_i[col_q]) begin
          // saturate at all ones
          if (hold_q != '1) begin
            hold_d = hold_q + HOLD_BITS'(1);
          end
        end else begin
          if (hold_ext < min_ext) begin
            res_o.key_event = kps_pkg::EvShort;
          end else begin
            res_o.key_event = kps_pkg::EvKey;
            res_o.key_char  = kps_pkg::key_char_lookup(row_q, col_q);
          end
          phase_d = kps_pkg::PhSettle;
          wait_d  = '0;
        end
      end
      default: begin
        phase_d = kps_pkg::PhSettle;
        if (wait_q < cfg_i.settle_ticks) begin
          wait_d = wait_inc;
        end else if (any_low) begin
          phase_d = kps_pkg::PhConfirm;
          wait_d  = '0;
        end else begin
          res_o.key_event = kps_pkg::EvEmpty;
          wait_d = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= kps_pkg::PhSettle;
      wait_q  <= '0;
      row_q   <= '0;
      col_q   <= '0;
      hold_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      wait_q  <= wait_d;
      row_q   <= row_d;
      col_q   <= col_d;
      hold_q  <= hold_d;
    end
  end

endmodule
